/* rtl/core/infix_to_postfix_converter_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Expects signals clk and rst in the scope of use.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ITP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itp: next-cycle check failed");

`endif

/* rtl/core/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg
// Operator codes, character constants and decode helpers for the converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int CHAR_W = 8;
  localparam int CODE_W = 3;

  localparam logic [CHAR_W-1:0] CH_ADD    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SUB    = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_MUL    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV    = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_POW    = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

  typedef enum logic [CODE_W-1:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_POW    = 3'd4,
    OP_LPAREN = 3'd5
  } op_code_t;

  typedef struct packed {
    logic     is_op;
    op_code_t code;
  } op_dec_t;

  function automatic op_dec_t decode_char(input logic [CHAR_W-1:0] c);
    op_dec_t d;
    d.is_op = 1'b1;
    d.code  = OP_ADD;
    case (c)
      CH_ADD:    d.code = OP_ADD;
      CH_SUB:    d.code = OP_SUB;
      CH_MUL:    d.code = OP_MUL;
      CH_DIV:    d.code = OP_DIV;
      CH_POW:    d.code = OP_POW;
      CH_LPAREN: d.code = OP_LPAREN;
      default:   d.is_op = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] code_char(input op_code_t code);
    logic [CHAR_W-1:0] c;
    case (code)
      OP_ADD:    c = CH_ADD;
      OP_SUB:    c = CH_SUB;
      OP_MUL:    c = CH_MUL;
      OP_DIV:    c = CH_DIV;
      OP_POW:    c = CH_POW;
      OP_LPAREN: c = CH_LPAREN;
      default:   c = CH_ADD;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] code_rank(input op_code_t code);
    logic [1:0] r;
    case (code)
      OP_ADD, OP_SUB: r = 2'd1;
      OP_MUL, OP_DIV: r = 2'd2;
      OP_POW:         r = 2'd3;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/itp_if.sv */
// ----------------------------------------------------------------------------
// itp channel interfaces
// Valid/ready channels for infix characters in and postfix results out.
// ----------------------------------------------------------------------------
interface itp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [itp_pkg::CHAR_W-1:0] in_char;

  modport source (output valid, output kind, output in_char, input ready);
  modport sink (input valid, input kind, input in_char, output ready);
endinterface

interface itp_out_if;
  logic                      valid;
  logic                      ready;
  logic [itp_pkg::CHAR_W-1:0] out_char;
  logic                      has_char;
  logic                      last;
  logic                      error;

  modport source (output valid, output out_char, output has_char, output last,
                  output error, input ready);
  modport sink (input valid, input out_char, input has_char, input last,
                input error, output ready);
endinterface

/* rtl/core/itp_ram.sv */
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/infix_to_postfix_converter_unit.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter: infix characters in, postfix characters out,
// operator stack held in a RAM and walked by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              handshake
//  expr      in   kind, in_char                        valid/ready
//  postfix   out  out_char, has_char, last, error      valid/ready
//
//  Operand, marker and error requests: accept, then result load.
//  Stack walk: each entry examined takes a RAM read of the top, then evaluate,
//  whether it is popped, dropped as the matching '(' or stops an operator's pops.
//  Push follows the walk, if any, as its own step. One request in flight at a time.
//  Reset (rst, synchronous) empties the stack; the RAM is not cleared.
//  A stalled postfix channel holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_unit_assert.svh"

module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 16
) (
  input logic  clk,
  input logic  rst,
  itp_in_if.sink    expr,
  itp_out_if.source postfix
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_READ,
    S_EVAL,
    S_PUSH
  } state_t;

  state_t state;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] lp_count;
  logic [CNT_W-1:0] count_m1;

  // current request
  logic                       cur_end;
  logic                       cur_rparen;
  itp_pkg::op_code_t          cur_code;
  logic [itp_pkg::CHAR_W-1:0] pend_char;
  logic                       pend_has;
  logic                       pend_last;
  logic                       pend_err;

  // output register
  logic                       out_valid;
  logic [itp_pkg::CHAR_W-1:0] out_char;
  logic                       out_has;
  logic                       out_last;
  logic                       out_err;

  logic                        out_free;
  logic                        out_load;
  logic                        last_pop;
  logic                        ovf_load;
  itp_pkg::op_dec_t            in_dec;
  logic [itp_pkg::CODE_W-1:0]  rd_data;
  itp_pkg::op_code_t           top_code;
  logic                        top_lp;
  logic                        do_emit;
  logic                        wr_en;

  assign out_free = !out_valid || postfix.ready;
  assign in_dec   = itp_pkg::decode_char(expr.in_char);
  assign count_m1 = count - ONE;
  assign top_code = itp_pkg::op_code_t'(rd_data);
  assign top_lp   = (top_code == itp_pkg::OP_LPAREN);
  assign wr_en    = (state == S_PUSH) && (count != FULL);

  // pop and emit the top entry in the evaluate step
  assign do_emit = cur_end || (cur_rparen && !top_lp) ||
                   (!cur_end && !cur_rparen && !top_lp &&
                    (itp_pkg::code_rank(top_code) >= itp_pkg::code_rank(cur_code)));

  assign last_pop = (state == S_EVAL) && do_emit && out_free && cur_end && (count == ONE);
  assign ovf_load = (state == S_PUSH) && (count == FULL) && out_free;
  assign out_load = out_free && ((state == S_SINGLE) ||
                                 ((state == S_EVAL) && do_emit) ||
                                 ((state == S_PUSH) && (count == FULL)));

  itp_ram #(
    .WIDTH (itp_pkg::CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (cur_code),
    .rd_addr (count_m1[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign expr.ready       = (state == S_IDLE);
  assign postfix.valid    = out_valid;
  assign postfix.out_char = out_char;
  assign postfix.has_char = out_has;
  assign postfix.last     = out_last;
  assign postfix.error    = out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      lp_count  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (postfix.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (expr.valid) begin
            cur_end    <= expr.kind;
            cur_rparen <= (expr.in_char == itp_pkg::CH_RPAREN);
            cur_code   <= in_dec.code;
            pend_char  <= '0;
            pend_has   <= 1'b0;
            pend_last  <= 1'b0;
            pend_err   <= 1'b0;
            if (expr.kind) begin
              if (count == '0) begin
                pend_last <= 1'b1;
                state     <= S_SINGLE;
              end else begin
                state <= S_READ;
              end
            end else if (expr.in_char == itp_pkg::CH_RPAREN) begin
              if (lp_count == '0) begin
                // no opening parenthesis anywhere on the stack
                count    <= '0;
                pend_err <= 1'b1;
                state    <= S_SINGLE;
              end else begin
                state <= S_READ;
              end
            end else if (!in_dec.is_op) begin
              pend_char <= expr.in_char;
              pend_has  <= 1'b1;
              state     <= S_SINGLE;
            end else if (in_dec.code == itp_pkg::OP_LPAREN || count == '0) begin
              state <= S_PUSH;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_SINGLE: begin
          if (out_free) begin
            out_char  <= pend_char;
            out_has   <= pend_has;
            out_last  <= pend_last;
            out_err   <= pend_err;
            state     <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (do_emit) begin
            if (out_free) begin
              out_char  <= itp_pkg::code_char(top_code);
              out_has   <= 1'b1;
              out_last  <= cur_end && (count == ONE);
              out_err   <= 1'b0;
              count     <= count_m1;
              if (top_lp) begin
                lp_count <= lp_count - ONE;
              end
              if (count == ONE) begin
                state <= cur_end ? S_IDLE : S_PUSH;
              end else begin
                state <= S_READ;
              end
            end
          end else if (cur_rparen) begin
            // matching opening parenthesis is dropped
            count    <= count_m1;
            lp_count <= lp_count - ONE;
            state    <= S_IDLE;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (count == FULL) begin
            if (out_free) begin
              out_char  <= '0;
              out_has   <= 1'b0;
              out_last  <= 1'b0;
              out_err   <= 1'b1;
              count     <= '0;
              lp_count  <= '0;
              state     <= S_IDLE;
            end
          end else begin
            count <= count + ONE;
            if (cur_code == itp_pkg::OP_LPAREN) begin
              lp_count <= lp_count + ONE;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ITP_ASSERT_IMPL(a_lp_within_count, 1'b1, (lp_count <= count) && (count <= FULL))
  `ITP_ASSERT_IMPL(a_err_no_char, out_valid && out_err, !out_has && !out_last)
  `ITP_ASSERT_NEXT(a_last_empties, last_pop, (count == '0) && (lp_count == '0) && out_last)
  `ITP_ASSERT_NEXT(a_overflow_clears, ovf_load, (count == '0) && (lp_count == '0) && out_err)

endmodule
